### hdl/alternation_substring_matcher_macros.svh
// Assertion shorthands shared by the matcher modules.
`ifndef ALTERNATION_SUBSTRING_MATCHER_MACROS_SVH
`define ALTERNATION_SUBSTRING_MATCHER_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASM_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/asm_pkg.sv
package asm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_EMPTY  = 2'd3
    } op_t;

    localparam logic [7:0] SEP_BYTE    = 8'h7C;
    localparam logic [7:0] ANCHOR_BYTE = 8'h5E;

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // Classified command handed from front to back.
    typedef struct packed {
        op_t        op;
        logic [7:0] sym;       // case-folded byte
        logic       is_sep;
        logic       is_caret;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } res_t;

endpackage

### hdl/asm_queue.sv
`include "alternation_substring_matcher_macros.svh"

module asm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             wr, rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr      = wr_en && !full;
    assign rd      = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASM_ASSERT_HOLDS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue count over depth")
    `ASM_ASSERT_NEXT(a_count_up, clk, rst_n, wr && !rd, count_reg == $past(count_reg) + 1'b1, "queue count did not advance on write")
    `ASM_ASSERT_NEXT(a_count_down, clk, rst_n, rd && !wr, count_reg == $past(count_reg) - 1'b1, "queue count did not drop on read")

endmodule

### hdl/asm_front.sv
module asm_front
    import asm_pkg::*;
(
    input  logic [1:0] operation,
    input  logic [7:0] symbol,
    input  logic       last,
    output cmd_t       cmd
);

    // Fold upper-case ASCII; separator and caret are untouched by the fold.
    always_comb
    begin
        cmd.op       = op_t'(operation);
        cmd.last     = last;
        cmd.is_sep   = (symbol == SEP_BYTE);
        cmd.is_caret = (symbol == ANCHOR_BYTE);
        if (symbol inside {[8'h41:8'h5A]})
        begin
            cmd.sym = symbol + 8'h20;
        end
        else
        begin
            cmd.sym = symbol;
        end
    end

endmodule

### hdl/asm_back.sv
`include "alternation_substring_matcher_macros.svh"

module asm_back
    import asm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_take,
    output res_t res,
    output logic res_push,
    input  logic res_full
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = $clog2(PATTERN_MAX);

    // Pattern cells: folded byte plus separator / caret marks.
    logic [7:0]             sym_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] sep_reg;
    logic [PATTERN_MAX-1:0] caret_reg;

    logic [LW-1:0]          len_reg, len_next;
    logic [PATTERN_MAX-1:0] act_reg, act_next;
    logic                   found_reg, found_next;
    logic                   started_reg, started_next;
    logic                   ovf_reg, ovf_next;

    logic [PATTERN_MAX-1:0] live, start, head, after, endn;
    logic [PATTERN_MAX-1:0] hit, shift_in, free_v;
    logic                   hit_end, free, need_res, go, wr_en;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_lane
            assign live[gi] = (len_reg > LW'(gi));
            if (gi == 0)
            begin : g_first
                assign start[gi] = 1'b1;
                assign after[gi] = 1'b0;
                assign shift_in[gi] = 1'b0;
            end
            else
            begin : g_rest
                assign start[gi] = sep_reg[gi-1];
                assign after[gi] = live[gi] && !start[gi] && start[gi-1] && caret_reg[gi-1];
                assign shift_in[gi] = hit[gi-1] && !endn[gi-1];
            end
            if (gi == PATTERN_MAX - 1)
            begin : g_tail
                assign endn[gi] = 1'b1;
            end
            else
            begin : g_mid
                assign endn[gi] = !live[gi+1] || sep_reg[gi+1];
            end
            assign head[gi] = live[gi] && start[gi] && caret_reg[gi];

            // Lane compares the text byte when a partial match, a fresh
            // alternative, or an anchor at text start offers this position.
            assign hit[gi] = live[gi] && !sep_reg[gi] && !head[gi]
                             && (act_reg[gi] || start[gi] || (after[gi] && !started_reg))
                             && (sym_reg[gi] == cmd.sym);

            // Empty alternative, lone caret, or trailing separator.
            assign free_v[gi] = live[gi] && (
                                    (start[gi] && (sep_reg[gi] || (caret_reg[gi] && endn[gi])))
                                 || (sep_reg[gi] && endn[gi] && (gi == PATTERN_MAX - 1
                                     || !live[(gi + 1) % PATTERN_MAX])));
        end
    endgenerate

    assign hit_end = |(hit & endn);
    assign free    = |free_v;

    assign need_res = ((cmd.op == OP_TEXT) && cmd.last) || (cmd.op == OP_EMPTY);
    assign go       = cmd_valid && !(need_res && res_full);
    assign cmd_take = go;
    assign res_push = go && need_res;

    assign res.matched  = (len_reg != '0)
                          && (((cmd.op == OP_TEXT) && (found_reg || hit_end)) || free);
    assign res.overflow = ovf_reg;

    always_comb
    begin
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        act_next     = '0;
        found_next   = 1'b0;
        started_next = 1'b0;
        wr_en        = 1'b0;
        case (cmd.op)
            OP_CLEAR:
            begin
                len_next = '0;
                ovf_next = 1'b0;
            end
            OP_APPEND:
            begin
                if (len_reg < LW'(PATTERN_MAX))
                begin
                    wr_en    = 1'b1;
                    len_next = len_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            OP_TEXT:
            begin
                if (!cmd.last)
                begin
                    act_next     = shift_in;
                    found_next   = found_reg || hit_end;
                    started_next = 1'b1;
                end
            end
            default:
            begin
                // empty text: result only, text state drops
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            act_reg     <= '0;
            found_reg   <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (go)
        begin
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            act_reg     <= act_next;
            found_reg   <= found_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && wr_en)
        begin
            sym_reg[len_reg[IW-1:0]]   <= cmd.sym;
            sep_reg[len_reg[IW-1:0]]   <= cmd.is_sep;
            caret_reg[len_reg[IW-1:0]] <= cmd.is_caret;
        end
    end

    `ASM_ASSERT_HOLDS(a_len_bound, clk, rst_n, len_reg <= LW'(PATTERN_MAX), "pattern length over capacity")
    `ASM_ASSERT_HOLDS(a_act_live, clk, rst_n, (act_reg & ~live) == '0, "active bit beyond pattern")
    `ASM_ASSERT_IMPLIES(a_found_started, clk, rst_n, found_reg, started_reg, "found without text")
    `ASM_ASSERT_NEXT(a_clear, clk, rst_n, go && (cmd.op == OP_CLEAR), (len_reg == '0) && !ovf_reg, "clear did not empty pattern")

endmodule

### hdl/alternation_substring_matcher.sv
// Results: a result is registered into the result queue at the edge at which
//   the back end takes its closing item (last text byte or empty text).
// Throughput: one item per cycle while no result waits on a full result queue;
//   the back end compares a text byte against every pattern cell in parallel.
// Reset: clears pattern length, overflow, text state and both queues; the
//   pattern bytes themselves are not cleared and are rewritten on append.
module alternation_substring_matcher
    import asm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] operation,
    input  logic [7:0] symbol,
    input  logic       last,
    output logic       empty,
    input  logic       pop,
    output logic       matched,
    output logic       pattern_overflow
);

    cmd_t cmd_in;
    cmd_t cmd_out;
    res_t res_in;
    res_t res_out;
    logic cmd_empty;
    logic cmd_take;
    logic res_push;
    logic res_full;

    // Front end: decode the operation and case-fold the byte.
    asm_front u_front (
        .operation (operation),
        .symbol    (symbol),
        .last      (last),
        .cmd       (cmd_in)
    );

    // Command queue decouples the input side from the matcher core; full
    // backpressures the producer only when the core has stalled.
    asm_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_take),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // Back end: pattern storage, bit-parallel active vector, result build.
    // It holds a result-producing transaction while the result queue is full.
    asm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_valid (!cmd_empty),
        .cmd_take  (cmd_take),
        .res       (res_in),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result queue: the oldest result sits on the ports while empty is low.
    asm_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign matched          = res_out.matched;
    assign pattern_overflow = res_out.overflow;

endmodule

### sim/tb_top.sv
module tb_top
    import asm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Pattern capacity of the instance; the reference behavior is kept at this size.
    localparam int PAT_CAP       = 64;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Extra idle time after the final drain, before the run ends.
    localparam int DRAIN_CYCLES  = 8;
    localparam int SCRIPT_ROWS   = 27;

    // One row of the directed script. When typed is set, want is the verdict
    // the row must produce; otherwise the verdict comes from the predictor.
    typedef struct packed {
        op_t        op;
        logic [7:0] sym;
        logic       fin;
        bit         typed;
        res_t       want;
    } row_t;

    localparam row_t STIM_ROWS [SCRIPT_ROWS] = '{
        // Empty pattern right after reset: nothing ever matches.
        '{OP_EMPTY,  8'h00,       1'b0, 1'b1, '{1'b0, 1'b0}},
        '{OP_TEXT,   "a",         1'b1, 1'b1, '{1'b0, 1'b0}},
        // Build "^Ab|<00><FF>^": an anchored alternative, then one with a
        // zero byte, the top byte and a caret that is only a literal.
        '{OP_APPEND, ANCHOR_BYTE, 1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_APPEND, "A",         1'b1, 1'b0, '{1'b0, 1'b0}},
        '{OP_APPEND, "b",         1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_APPEND, SEP_BYTE,    1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_APPEND, 8'h00,       1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_APPEND, 8'hFF,       1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_APPEND, ANCHOR_BYTE, 1'b0, 1'b0, '{1'b0, 1'b0}},
        // Anchored hit, case folded.
        '{OP_TEXT,   "a",         1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_TEXT,   "B",         1'b1, 1'b0, '{1'b0, 1'b0}},
        // Same bytes away from the start must not satisfy the anchor.
        '{OP_TEXT,   "x",         1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_TEXT,   "a",         1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_TEXT,   "b",         1'b1, 1'b0, '{1'b0, 1'b0}},
        // Zero byte, top byte and literal caret in the text.
        '{OP_TEXT,   8'h00,       1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_TEXT,   8'hFF,       1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_TEXT,   ANCHOR_BYTE, 1'b1, 1'b0, '{1'b0, 1'b0}},
        // Trailing separator adds an empty alternative: empty text matches.
        '{OP_APPEND, SEP_BYTE,    1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_EMPTY,  8'hFF,       1'b1, 1'b1, '{1'b1, 1'b0}},
        // Clear ignores its symbol and last fields.
        '{OP_CLEAR,  8'hFF,       1'b1, 1'b0, '{1'b0, 1'b0}},
        // A lone caret alternative matches anything, even empty text.
        '{OP_APPEND, ANCHOR_BYTE, 1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_EMPTY,  8'h00,       1'b0, 1'b1, '{1'b1, 1'b0}},
        // Append in the middle of a text drops that text.
        '{OP_APPEND, "Z",         1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_TEXT,   "z",         1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_APPEND, "y",         1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_TEXT,   "Z",         1'b0, 1'b0, '{1'b0, 1'b0}},
        '{OP_TEXT,   "Y",         1'b1, 1'b0, '{1'b0, 1'b0}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] operation = OP_CLEAR;
    logic [7:0] symbol = 8'h00;
    logic       last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       matched;
    logic       pattern_overflow;

    // Side information that travels with the item on the input ports.
    bit   row_typed = 1'b0;
    res_t row_want = '0;

    bit   send_quiet = 1'b0;
    bit   pop_quiet = 1'b0;
    int   items_sent = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    res_t pending_verdicts [$];

    // Predictor state: the pattern, the partial-match vector and the flags.
    logic [7:0]         pat_mem [PAT_CAP];
    int                 pat_len = 0;
    logic [PAT_CAP-1:0] live_pos = '0;
    bit                 hit_seen = 1'b0;
    bit                 text_on = 1'b0;
    bit                 pat_dropped = 1'b0;

    alternation_substring_matcher #(
        .PATTERN_MAX(PAT_CAP)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .operation        (operation),
        .symbol           (symbol),
        .last             (last),
        .empty            (empty),
        .pop              (pop),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fold ASCII upper case onto lower case; every other byte is exact.
    function automatic logic [7:0] fold_case(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    // Position i lies past the end of its alternative.
    function automatic bit alt_done(int i);
        return i >= pat_len || pat_mem[i] == SEP_BYTE;
    endfunction

    // True if some alternative is empty or a lone caret, so matches any text.
    function automatic bit has_open_alt();
        bit at_head;
        at_head = 1'b1;
        if (pat_len == 0)
        begin
            return 1'b0;
        end
        for (int i = 0; i <= pat_len; i++)
        begin
            if (at_head)
            begin
                if (alt_done(i))
                begin
                    return 1'b1;
                end
                if (pat_mem[i] == ANCHOR_BYTE && alt_done(i + 1))
                begin
                    return 1'b1;
                end
            end
            at_head = i < pat_len && pat_mem[i] == SEP_BYTE;
        end
        return 1'b0;
    endfunction

    function automatic void drop_text();
        live_pos = '0;
        hit_seen = 1'b0;
        text_on = 1'b0;
    endfunction

    // Advance every partial match by one text byte.
    function automatic void scan_text(logic [7:0] c);
        logic [PAT_CAP-1:0] nxt;
        logic [7:0]         fc;
        logic [7:0]         b;
        bit                 at_head;
        bit                 after_caret;
        bit                 cand;
        nxt = '0;
        fc = fold_case(c);
        at_head = 1'b1;
        after_caret = 1'b0;
        for (int i = 0; i < pat_len; i++)
        begin
            b = pat_mem[i];
            if (b == SEP_BYTE)
            begin
                at_head = 1'b1;
                after_caret = 1'b0;
                continue;
            end
            cand = live_pos[i];
            if (at_head)
            begin
                at_head = 1'b0;
                if (b == ANCHOR_BYTE)
                begin
                    after_caret = 1'b1;
                    continue;
                end
                // Unanchored alternatives may start at any byte.
                cand = 1'b1;
            end
            else if (after_caret && !text_on)
            begin
                // Anchored alternatives start only at the first text byte.
                cand = 1'b1;
            end
            after_caret = 1'b0;
            if (cand && fold_case(b) == fc)
            begin
                if (alt_done(i + 1))
                begin
                    hit_seen = 1'b1;
                end
                else
                begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end
        live_pos = nxt;
        text_on = 1'b1;
    endfunction

    // Apply one accepted transaction; return 1 with the verdict if it closes a text.
    function automatic bit predict_verdict(op_t op, logic [7:0] sym, logic fin,
                                           output res_t verdict);
        bit give;
        give = 1'b0;
        verdict = '0;
        case (op)
            OP_CLEAR:
            begin
                pat_len = 0;
                pat_dropped = 1'b0;
                drop_text();
            end
            OP_APPEND:
            begin
                if (pat_len < PAT_CAP)
                begin
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end
                else
                begin
                    pat_dropped = 1'b1;
                end
                drop_text();
            end
            OP_TEXT:
            begin
                scan_text(sym);
                give = fin;
            end
            default:
            begin
                drop_text();
                give = 1'b1;
            end
        endcase
        if (give)
        begin
            verdict.matched = pat_len > 0 && (hit_seen || has_open_alt());
            verdict.overflow = pat_dropped;
            drop_text();
        end
        return give;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check popped verdicts, then predict the accepted transaction.
    // A verdict is popped only at an edge after the one that accepts its closing
    // item, so the check never needs an expectation queued at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t got_exp;
        res_t nxt_exp;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected verdict matched=%0b overflow=%0b",
                             $time, matched, pattern_overflow);
                end
                else
                begin
                    got_exp = pending_verdicts.pop_front();
                    if (matched !== got_exp.matched)
                    begin
                        error_count++;
                        $display("%0t: matched expected %0b, got %0b",
                                 $time, got_exp.matched, matched);
                    end
                    if (pattern_overflow !== got_exp.overflow)
                    begin
                        error_count++;
                        $display("%0t: pattern_overflow expected %0b, got %0b",
                                 $time, got_exp.overflow, pattern_overflow);
                    end
                end
            end
            if (push && !full)
            begin
                if (predict_verdict(op_t'(operation), symbol, last, nxt_exp))
                begin
                    // Typed rows override the predictor with the hand-read verdict.
                    if (row_typed)
                    begin
                        nxt_exp = row_want;
                    end
                    pending_verdicts.push_back(nxt_exp);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int idle_cycles(bit quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // Mostly a small case-mixed alphabet so alternatives hit often; also
    // the bytes around the fold range, carets and any byte.
    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 13))
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'h40 : 8'h5B;
            2: return $urandom_range(0, 1) ? 8'h60 : 8'h7B;
            3: return $urandom_range(0, 1) ? "Z" : "z";
            4: return ANCHOR_BYTE;
            5: return "A";
            6: return "B";
            7: return "C";
            default: return 8'($urandom_range(8'h61, 8'h63));
        endcase
    endfunction

    function automatic logic [7:0] pattern_byte();
        case ($urandom_range(0, 11))
            0: return SEP_BYTE;
            1: return ANCHOR_BYTE;
            default: return text_byte();
        endcase
    endfunction

    // Drive one transaction at the falling edge and hold it until accepted.
    // Keep push high across back-to-back transactions; lower it only for a gap.
    task automatic send_item(op_t op, logic [7:0] sym, logic fin, bit typed, res_t want);
        int gap;
        gap = idle_cycles(send_quiet);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        operation <= op;
        symbol <= sym;
        last <= fin;
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_plain(op_t op, logic [7:0] sym, logic fin);
        send_item(op, sym, fin, 1'b0, '0);
    endtask

    // Drop push and hold off until every queued verdict has been popped.
    task automatic hold_until_drained();
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    // Load a well-formed pattern: one to three alternatives, some anchored,
    // an occasional empty alternative and an occasional trailing separator.
    task automatic load_pattern();
        int n_alt;
        int body;
        n_alt = $urandom_range(1, 3);
        for (int a = 0; a < n_alt; a++)
        begin
            if (a > 0)
            begin
                send_plain(OP_APPEND, SEP_BYTE, 1'($urandom));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                send_plain(OP_APPEND, ANCHOR_BYTE, 1'($urandom));
            end
            body = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            repeat (body) send_plain(OP_APPEND, text_byte(), 1'($urandom));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            send_plain(OP_APPEND, SEP_BYTE, 1'($urandom));
        end
    endtask

    // Stream a few texts; an empty length becomes an empty-text transaction,
    // and now and then an append cuts a text short.
    task automatic stream_texts();
        int n_txt;
        int len;
        bit cut;
        n_txt = $urandom_range(1, 6);
        repeat (n_txt)
        begin
            len = $urandom_range(0, 8);
            if (len == 0)
            begin
                send_plain(OP_EMPTY, 8'($urandom), 1'($urandom));
                continue;
            end
            cut = 1'b0;
            for (int k = 0; k < len && !cut; k++)
            begin
                send_plain(OP_TEXT, text_byte(), k == len - 1);
                if (k < len - 1 && $urandom_range(0, 24) == 0)
                begin
                    send_plain(OP_APPEND, pattern_byte(), 1'($urandom));
                    cut = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase_no;
        int kind;
        phase_no = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed script.
        for (int r = 0; r < SCRIPT_ROWS; r++)
        begin
            send_item(STIM_ROWS[r].op, STIM_ROWS[r].sym, STIM_ROWS[r].fin,
                      STIM_ROWS[r].typed, STIM_ROWS[r].want);
        end

        // Random phases: mostly a fresh pattern plus texts, some overflow
        // fills, some raw noise over every field.
        while (items_sent < SCRIPT_ROWS + RANDOM_ITEMS)
        begin
            phase_no++;
            send_quiet = ($urandom_range(0, 4) == 0);
            if (phase_no % 25 == 1)
            begin
                hold_until_drained();
            end
            kind = $urandom_range(0, 19);
            if (kind < 2)
            begin
                repeat ($urandom_range(4, 16))
                begin
                    send_plain(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                end
            end
            else
            begin
                if (kind == 2)
                begin
                    // Fill around and past capacity to raise the overflow flag.
                    send_plain(OP_CLEAR, 8'($urandom), 1'($urandom));
                    repeat ($urandom_range(PAT_CAP - 2, PAT_CAP + 8))
                    begin
                        send_plain(OP_APPEND, pattern_byte(), 1'($urandom));
                    end
                end
                else
                begin
                    if ($urandom_range(0, 7) != 0)
                    begin
                        send_plain(OP_CLEAR, 8'($urandom), 1'($urandom));
                    end
                    load_pattern();
                end
                stream_texts();
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: stall a random number of cycles per verdict, with
    // stretches of back-to-back pops, then hold pop until one is taken.
    initial
    begin
        int stall;
        int pops;
        pops = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (pops % 40 == 0)
            begin
                pop_quiet = ($urandom_range(0, 3) == 0);
            end
            stall = idle_cycles(pop_quiet);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
            begin
                @(posedge clk);
            end
            pops++;
            @(negedge clk);
        end
    end

endmodule

### filelist.f
+incdir+hdl
hdl/asm_pkg.sv
hdl/asm_queue.sv
hdl/asm_front.sv
hdl/asm_back.sv
hdl/alternation_substring_matcher.sv
sim/tb_top.sv
